### src/sliding_window_byte_rate_meter_core_assert.svh
// Assertion macros used by the rate meter checker
`ifndef SLIDING_WINDOW_BYTE_RATE_METER_CORE_ASSERT_SVH
`define SLIDING_WINDOW_BYTE_RATE_METER_CORE_ASSERT_SVH

// Consequence holds in the same cycle as the trigger
`define SWBRM_ASSERT_NOW(lbl, trig, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error("rate meter assertion failed");

// Consequence holds starting in the cycle after the trigger
`define SWBRM_ASSERT_NEXT(lbl, trig, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("rate meter assertion failed");

`endif

### src/swbrm_pkg.sv
// Shared widths and limits of the byte rate meter
package swbrm_pkg;

   localparam int COUNT_W = 32;
   localparam int BYTE_W = 16;
   localparam int ITER_W = $clog2(COUNT_W);

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(COUNT_W - 1);

endpackage

### src/sliding_window_byte_rate_meter_core.sv
// Sliding window byte rate meter built around one shared add/subtract unit
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------
//   req     | in        | req_valid, req_ready, req_new_second, req_byte_count
//   rsp     | out       | rsp_valid, rsp_ready, rsp_current_bytes, rsp_average_rate
//
// An item goes from acceptance to result through these steps with new_second
// set: drop the oldest bucket, merge the closed one into the window sum, the
// saturating add, and 32 restoring divide steps on the shared adder. Without
// new_second the first two are skipped. With an empty window the divide is skipped.
// Reset clears all buckets, valid marks, the window sum and the seconds count.
// A waiting result does not block the next item; a new result waits for a free
// output register.
module sliding_window_byte_rate_meter_core #(
   parameter int WINDOW_SECONDS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_new_second,
   input  logic [swbrm_pkg::BYTE_W-1:0]  req_byte_count,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [swbrm_pkg::COUNT_W-1:0] rsp_current_bytes,
   output logic [swbrm_pkg::COUNT_W-1:0] rsp_average_rate
);
   import swbrm_pkg::*;

   localparam int CNT_W = $clog2(WINDOW_SECONDS + 1);
   localparam int SUM_W = COUNT_W + $clog2(WINDOW_SECONDS);
   localparam int ALU_W = SUM_W + 1;
   localparam int REM_W = CNT_W + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DROP  = 3'd1;
   localparam logic [2:0] ST_MERGE = 3'd2;
   localparam logic [2:0] ST_ACC   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [COUNT_W-1:0] cur_ff, cur_in;
   logic [COUNT_W-1:0] completed_ff [WINDOW_SECONDS];
   logic [COUNT_W-1:0] completed_in [WINDOW_SECONDS];
   logic               valid_ff [WINDOW_SECONDS];
   logic               valid_in [WINDOW_SECONDS];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [BYTE_W-1:0]  add_ff, add_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0] quo_ff, quo_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_cur_ff, rsp_cur_in;
   logic [COUNT_W-1:0] rsp_avg_ff, rsp_avg_in;

   // shared adder / subtractor
   logic [ALU_W-1:0] alu_a, alu_b, alu_res;
   logic             alu_sub;
   logic             div_neg;
   logic [REM_W-1:0] rem_shift;

   assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
   assign div_neg = alu_res[ALU_W-1];
   assign rem_shift = {rem_ff[REM_W-2:0], quo_ff[COUNT_W-1]};

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_current_bytes = rsp_cur_ff;
   assign rsp_average_rate = rsp_avg_ff;

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      completed_in = completed_ff;
      valid_in = valid_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      iter_in = iter_ff;
      add_in = add_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      rsp_cur_in = rsp_cur_ff;
      rsp_avg_in = rsp_avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      alu_a = '0;
      alu_b = '0;
      alu_sub = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               add_in = req_byte_count;
               state_in = req_new_second ? ST_DROP : ST_ACC;
            end
         end
         ST_DROP: begin
            // drop the oldest bucket from the sum, or count a newly filled second
            alu_a = ALU_W'(sum_ff);
            alu_b = ALU_W'(completed_ff[WINDOW_SECONDS-1]);
            alu_sub = 1'b1;
            if (valid_ff[WINDOW_SECONDS-1]) begin
               sum_in = alu_res[SUM_W-1:0];
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            completed_in[0] = cur_ff;
            valid_in[0] = 1'b1;
            for (int i = 1; i < WINDOW_SECONDS; i++) begin
               completed_in[i] = completed_ff[i-1];
               valid_in[i] = valid_ff[i-1];
            end
            cur_in = '0;
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            alu_a = ALU_W'(sum_ff);
            alu_b = ALU_W'(completed_ff[0]);
            sum_in = alu_res[SUM_W-1:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            alu_a = ALU_W'(cur_ff);
            alu_b = ALU_W'(add_ff);
            cur_in = alu_res[COUNT_W] ? COUNT_MAX : alu_res[COUNT_W-1:0];
            // the mean fits 32 bits, so the bits above start as the remainder
            rem_in = REM_W'(sum_ff >> COUNT_W);
            quo_in = sum_ff[COUNT_W-1:0];
            iter_in = '0;
            state_in = (cnt_ff == '0) ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            alu_a = ALU_W'(rem_shift);
            alu_b = ALU_W'(cnt_ff);
            alu_sub = 1'b1;
            rem_in = div_neg ? rem_shift : alu_res[REM_W-1:0];
            quo_in = {quo_ff[COUNT_W-2:0], !div_neg};
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cur_in = cur_ff;
               rsp_avg_in = (cnt_ff == '0) ? '0 : quo_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
         iter_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_SECONDS; i++) begin
            completed_ff[i] <= '0;
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         iter_ff <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         completed_ff <= completed_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      add_ff <= add_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      rsp_cur_ff <= rsp_cur_in;
      rsp_avg_ff <= rsp_avg_in;
   end

endmodule

### src/swbrm_checker.sv
// Port-level checker for the byte rate meter, bound to the top level
`include "sliding_window_byte_rate_meter_core_assert.svh"

module swbrm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [swbrm_pkg::COUNT_W-1:0] rsp_current_bytes,
   input logic [swbrm_pkg::COUNT_W-1:0] rsp_average_rate
);

   // a stalled item stays
   `SWBRM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `SWBRM_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready,
      $stable(rsp_current_bytes) && $stable(rsp_average_rate))

   // an accepted item keeps the block busy once it is taken
   `SWBRM_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready,
      !req_ready ##1 !req_ready)

   // a result only appears at the end of work on an item
   `SWBRM_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(!req_ready))

endmodule

bind sliding_window_byte_rate_meter_core swbrm_checker u_swbrm_checker (.*);

### tb/swbrm_rate_monitor.sv
// Channel monitor for the byte rate meter: predicts every reading and compares
`timescale 1ns / 100ps

module swbrm_rate_monitor #(
   parameter int WINDOW = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_new_second,
   input  logic [swbrm_pkg::BYTE_W-1:0]  req_byte_count,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [swbrm_pkg::COUNT_W-1:0] rsp_current_bytes,
   input  logic [swbrm_pkg::COUNT_W-1:0] rsp_average_rate,
   output int                            mismatch_count,
   output int                            readings_due
);

   import swbrm_pkg::*;

   typedef struct packed {
      logic [COUNT_W-1:0] current_bytes;
      logic [COUNT_W-1:0] average_rate;
   } meter_reading_type;

   // [0] is the open second, [1..WINDOW] the closed ones, newest first
   logic [COUNT_W-1:0] sec_count [0:WINDOW];
   logic               second_seen [0:WINDOW-1];
   logic [COUNT_W+7:0] window_total;
   int unsigned        closed_seconds;

   meter_reading_type expected_readings [$];

   function automatic meter_reading_type advance_meter(input logic tick,
                                                       input logic [BYTE_W-1:0] add);
      logic [COUNT_W:0] total;
      meter_reading_type reading;
      if (tick) begin
         // drop the oldest second, or grow the window while it is not full
         if (second_seen[WINDOW-1])
            window_total = window_total - sec_count[WINDOW];
         else
            closed_seconds++;
         for (int i = WINDOW; i > 0; i--)
            sec_count[i] = sec_count[i-1];
         for (int i = WINDOW - 1; i > 0; i--)
            second_seen[i] = second_seen[i-1];
         second_seen[0] = 1'b1;
         window_total = window_total + sec_count[1];
         sec_count[0] = '0;
      end
      total = {1'b0, sec_count[0]} + add;
      sec_count[0] = total[COUNT_W] ? COUNT_MAX : total[COUNT_W-1:0];
      reading.current_bytes = sec_count[0];
      reading.average_rate = (closed_seconds == 0) ? '0
                                                  : COUNT_W'(window_total / closed_seconds);
      return reading;
   endfunction

   always @(posedge clock) begin
      meter_reading_type want;
      if (reset) begin
         for (int i = 0; i <= WINDOW; i++)
            sec_count[i] = '0;
         for (int i = 0; i < WINDOW; i++)
            second_seen[i] = 1'b0;
         window_total = '0;
         closed_seconds = 0;
         expected_readings.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected reading: current %0d average %0d",
                           rsp_current_bytes, rsp_average_rate);
            end else begin
               want = expected_readings.pop_front();
               if (want.current_bytes !== rsp_current_bytes ||
                   want.average_rate !== rsp_average_rate) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: current exp %0d got %0d, average exp %0d got %0d",
                              want.current_bytes, rsp_current_bytes,
                              want.average_rate, rsp_average_rate);
               end
            end
         end
         if (req_valid && req_ready)
            expected_readings.push_back(advance_meter(req_new_second, req_byte_count));
      end
      readings_due = expected_readings.size();
   end

endmodule

### tb/sliding_window_byte_rate_meter_core_tb.sv
// Stimulus and verdict for the sliding window byte rate meter
`timescale 1ns / 100ps

module sliding_window_byte_rate_meter_core_tb;

   import swbrm_pkg::*;

   localparam int WINDOW       = 8;
   localparam int RANDOM_ITEMS = 740;
   localparam int BURST_ITEMS  = 40;
   localparam int STALL_AFTER  = 150;
   localparam int STALL_CYCLES = 800;
   localparam int DRAIN_CYCLES = 80;
   localparam int IDLE_LIMIT   = 4000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_new_second = 1'b0;
   logic [BYTE_W-1:0]  req_byte_count = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [COUNT_W-1:0] rsp_current_bytes;
   logic [COUNT_W-1:0] rsp_average_rate;

   int mismatch_count;
   int readings_due;
   int idle_cycles = 0;
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sliding_window_byte_rate_meter_core #(
      .WINDOW_SECONDS(WINDOW)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_new_second   (req_new_second),
      .req_byte_count   (req_byte_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_current_bytes(rsp_current_bytes),
      .rsp_average_rate (rsp_average_rate)
   );

   swbrm_rate_monitor #(
      .WINDOW(WINDOW)
   ) u_rate_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_new_second   (req_new_second),
      .req_byte_count   (req_byte_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_current_bytes(rsp_current_bytes),
      .rsp_average_rate (rsp_average_rate),
      .mismatch_count   (mismatch_count),
      .readings_due     (readings_due)
   );

   // Offer one item and return at the edge that accepts it, valid still high
   task automatic offer_item(input logic tick, input logic [BYTE_W-1:0] bytes);
      int gap;
      bit taken;
      gap = sender_idles ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_new_second <= tick;
      req_byte_count <= bytes;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Receiver: random hold-off per reading, one long stall to back up the input
   initial begin
      int gap;
      int readings_taken;
      bit taken;
      readings_taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (readings_taken == STALL_AFTER)
            gap = STALL_CYCLES;
         else
            gap = receiver_idles ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(negedge clock);
            taken = rsp_valid;
            @(posedge clock);
         end while (!taken);
         readings_taken++;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      int n;
      int jump;
      int mode_left;
      logic tick;
      logic [BYTE_W-1:0] bytes;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty window, field extremes, first tick, window wrap
      offer_item(1'b0, 16'h0000);
      offer_item(1'b0, 16'hFFFF);
      offer_item(1'b0, 16'h0001);
      offer_item(1'b1, 16'h0000);
      offer_item(1'b1, 16'hFFFF);
      offer_item(1'b0, 16'h8000);
      for (int i = 0; i < 10; i++)
         offer_item(1'b1, 16'(16'h1357 * (i + 1)));
      offer_item(1'b0, 16'h5555);
      offer_item(1'b0, 16'hAAAA);
      offer_item(1'b1, 16'h0000);
      offer_item(1'b0, 16'h0000);

      // back-to-back run of full-size items in one second, no idling
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      offer_item(1'b1, 16'h0000);
      repeat (BURST_ITEMS) offer_item(1'b0, 16'hFFFF);
      offer_item(1'b1, 16'h0001);
      offer_item(1'b0, 16'hFFFF);

      n = 0;
      mode_left = 0;
      while (n < RANDOM_ITEMS) begin
         if (mode_left <= 0) begin
            mode_left = $urandom_range(20, 60);
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 15) == 0) begin
            // clock jump of several seconds
            jump = $urandom_range(2, 10);
            repeat (jump) offer_item(1'b1, 16'h0000);
            n += jump;
            mode_left -= jump;
         end else begin
            tick = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
               0:       bytes = 16'h0000;
               1:       bytes = 16'hFFFF;
               2:       bytes = 16'($urandom_range(0, 255));
               default: bytes = 16'($urandom_range(0, 65535));
            endcase
            offer_item(tick, bytes);
            n++;
            mode_left--;
         end
      end
      req_valid <= 1'b0;

      @(negedge clock);
      while (readings_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && readings_due == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
